[src/prdi_pkg.sv]
// shared types and constants of the property record dedup interner
package prdi_pkg;

    // field widths
    localparam int CAT_W          = 8;
    localparam int DELTA_W        = 22;
    localparam int RECORD_INDEX_W = 8;

    // stored key halves: {first, second, upper} and {lower, title}
    localparam int KEY_A_W = 2 * CAT_W + DELTA_W;
    localparam int KEY_B_W = 2 * DELTA_W;

    // default dictionary depth
    localparam int DICT_ENTRIES_DEF = 256;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

endpackage

[src/prdi_ram.sv]
// generic single-port-write, registered-read ram
module prdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/property_record_dedup_interner.sv]
// top level of the property record dedup interner
//
// The block interns character property records (a two-letter category and
// three signed case-mapping offsets) into a dictionary of distinct records
// kept in arrival order. A request is taken when start is high and busy is
// low. The block answers each request with exactly one result, shown for a
// single cycle with o_result_valid high; the receiver cannot stall it, so
// the result must be captured in that cycle. The result gives the index of
// the equal stored record, or, for a record not seen before, the index at
// which it was appended with o_is_new set. If the dictionary is already
// full and the record is new, nothing is stored, the index reads 0 and
// o_overflow is set. Timing: the dictionary lives in two synchronous RAMs
// that are scanned linearly, one entry per cycle, with the read of the next
// entry overlapping the compare of the current one. A request against a
// non-empty dictionary keeps busy high until the equal entry has been
// compared, or, for a new record, until the last entry has been compared,
// so an earlier match ends the search sooner; against an empty
// dictionary the record is appended at once, busy never rises and the
// result shows in the cycle after the request is taken. Otherwise the
// result shows in the first cycle with busy low again, so a new request may
// be presented in that same cycle. The RAM read port sets the pace. There
// is no clearing pass after reset: only entries below the fill count are
// ever compared.
module property_record_dedup_interner #(
    parameter int DICT_ENTRIES = prdi_pkg::DICT_ENTRIES_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic        [prdi_pkg::CAT_W-1:0]          i_category_first,
    input  logic        [prdi_pkg::CAT_W-1:0]          i_category_second,
    input  logic signed [prdi_pkg::DELTA_W-1:0]        i_upper_delta,
    input  logic signed [prdi_pkg::DELTA_W-1:0]        i_lower_delta,
    input  logic signed [prdi_pkg::DELTA_W-1:0]        i_title_delta,
    output logic                                       o_result_valid,
    output logic        [prdi_pkg::RECORD_INDEX_W-1:0] o_record_index,
    output logic                                       o_is_new,
    output logic                                       o_overflow
);

    import prdi_pkg::*;

    // index into the dictionary and fill count (which can hold the depth)
    localparam int IDX_W = $clog2(DICT_ENTRIES);
    localparam int CNT_W = $clog2(DICT_ENTRIES + 1);

    // sequencer and fill count
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    // scan pointers: next address to read, and the entry now on the read port
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic             r_cmp_vld, n_cmp_vld;

    // latched request key, no reset needed
    logic [KEY_A_W-1:0] r_key_a, n_key_a;
    logic [KEY_B_W-1:0] r_key_b, n_key_b;

    // result registers
    logic                      r_res_vld, n_res_vld;
    logic [RECORD_INDEX_W-1:0] r_res_idx, n_res_idx;
    logic                      r_res_new, n_res_new;
    logic                      r_res_ovf, n_res_ovf;

    // ram ports
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [KEY_A_W-1:0] wr_data_a;
    logic [KEY_B_W-1:0] wr_data_b;
    logic [IDX_W-1:0]   rd_addr;
    logic [KEY_A_W-1:0] rd_data_a;
    logic [KEY_B_W-1:0] rd_data_b;

    logic accept;
    logic hit;
    logic last_cmp;
    logic full;
    logic [KEY_A_W-1:0] in_key_a;
    logic [KEY_B_W-1:0] in_key_b;

    // {first, second, upper} and {lower, title}
    prdi_ram #(
        .WIDTH (KEY_A_W),
        .DEPTH (DICT_ENTRIES)
    ) u_ram_cat_upper (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data_a),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data_a)
    );

    prdi_ram #(
        .WIDTH (KEY_B_W),
        .DEPTH (DICT_ENTRIES)
    ) u_ram_lower_title (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data_b),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data_b)
    );

    assign in_key_a = {i_category_first, i_category_second, i_upper_delta};
    assign in_key_b = {i_lower_delta, i_title_delta};

    assign accept   = start && (r_state == ST_IDLE);
    assign hit      = r_cmp_vld && (rd_data_a == r_key_a) && (rd_data_b == r_key_b);
    assign last_cmp = r_cmp_vld && (CNT_W'(r_cmp_idx) == r_count - CNT_W'(1));
    assign full     = (r_count == CNT_W'(DICT_ENTRIES));

    // scan reads the next address every cycle; stale reads are ignored
    assign rd_addr = r_rd_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_cmp_idx <= '0;
            r_cmp_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_idx  <= n_rd_idx;
            r_cmp_idx <= n_cmp_idx;
            r_cmp_vld <= n_cmp_vld;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_a   <= n_key_a;
        r_key_b   <= n_key_b;
        r_res_idx <= n_res_idx;
        r_res_new <= n_res_new;
        r_res_ovf <= n_res_ovf;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_cmp_idx = r_cmp_idx;
        n_cmp_vld = 1'b0;
        n_key_a   = r_key_a;
        n_key_b   = r_key_b;
        n_res_vld = 1'b0;
        n_res_idx = r_res_idx;
        n_res_new = r_res_new;
        n_res_ovf = r_res_ovf;
        wr_en     = 1'b0;
        wr_addr   = r_count[IDX_W-1:0];
        wr_data_a = r_key_a;
        wr_data_b = r_key_b;

        unique case (r_state)
            ST_IDLE: begin
                n_rd_idx = '0;
                if (accept) begin
                    n_key_a = in_key_a;
                    n_key_b = in_key_b;
                    if (r_count == '0) begin
                        // empty dictionary: append straight away at index 0
                        wr_en     = 1'b1;
                        wr_data_a = in_key_a;
                        wr_data_b = in_key_b;
                        n_count   = CNT_W'(1);
                        n_res_vld = 1'b1;
                        n_res_idx = '0;
                        n_res_new = 1'b1;
                        n_res_ovf = 1'b0;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // issue the next read while comparing the previous one
                if (r_rd_idx < r_count) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx[IDX_W-1:0];
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                end
                if (hit) begin
                    n_state   = ST_IDLE;
                    n_cmp_vld = 1'b0;
                    n_res_vld = 1'b1;
                    n_res_idx = RECORD_INDEX_W'(r_cmp_idx);
                    n_res_new = 1'b0;
                    n_res_ovf = 1'b0;
                end else if (last_cmp) begin
                    n_state   = ST_IDLE;
                    n_cmp_vld = 1'b0;
                    n_res_vld = 1'b1;
                    if (full) begin
                        // new record, no room: table untouched
                        n_res_idx = '0;
                        n_res_new = 1'b0;
                        n_res_ovf = 1'b1;
                    end else begin
                        wr_en     = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                        n_res_idx = RECORD_INDEX_W'(r_count);
                        n_res_new = 1'b1;
                        n_res_ovf = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_res_vld;
    assign o_record_index = r_res_idx;
    assign o_is_new       = r_res_new;
    assign o_overflow     = r_res_ovf;

endmodule

[src/prdi_checker.sv]
// port-level checks of the property record dedup interner and their bind
module prdi_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 o_result_valid,
    input logic [prdi_pkg::RECORD_INDEX_W-1:0]  o_record_index,
    input logic                                 o_is_new,
    input logic                                 o_overflow
);

    // a result only shows once the search has ended
    a_res_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // an accepted request either keeps the block busy or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("request accepted but dropped");

    // every end of a search gives a result
    a_fall_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("search ended without a result");

    // overflow is never a new entry and carries index zero
    a_overflow_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_overflow) |-> (!o_is_new && (o_record_index == '0)))
        else $error("bad overflow result");

endmodule

bind property_record_dedup_interner prdi_checker u_prdi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_record_index (o_record_index),
    .o_is_new       (o_is_new),
    .o_overflow     (o_overflow)
);

[tb/sv/tb_top.sv]
// self-checking testbench for the property record dedup interner
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prdi_pkg::*;

    // dictionary depth of the instance under test
    localparam int DICT_DEPTH = DICT_ENTRIES_DEF;
    localparam int RECORD_W = 2 * CAT_W + 3 * DELTA_W;
    localparam int RANDOM_ITEMS = 1740;
    // a full scan plus result cycle, with margin, for the final drain
    localparam int DRAIN_CYCLES = 2 * DICT_DEPTH + 16;
    // worst case is a full scan per request plus sender gaps; taken several times over
    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam int REPORT_MAX = 10;

    // one property record as it is presented to the block
    typedef struct packed {
        logic        [CAT_W-1:0]   cat_first;
        logic        [CAT_W-1:0]   cat_second;
        logic signed [DELTA_W-1:0] upper_delta;
        logic signed [DELTA_W-1:0] lower_delta;
        logic signed [DELTA_W-1:0] title_delta;
    } t_prop_record;

    // one answer of the block
    typedef struct packed {
        logic [RECORD_INDEX_W-1:0] record_index;
        logic                      is_new;
        logic                      overflow;
    } t_answer;

    // directed stimulus: when known is set the answer is typed in, else predicted
    typedef struct packed {
        t_prop_record rec;
        logic         known;
        t_answer      want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic        [CAT_W-1:0]          i_category_first = '0;
    logic        [CAT_W-1:0]          i_category_second = '0;
    logic signed [DELTA_W-1:0]        i_upper_delta = '0;
    logic signed [DELTA_W-1:0]        i_lower_delta = '0;
    logic signed [DELTA_W-1:0]        i_title_delta = '0;
    logic                             o_result_valid;
    logic        [RECORD_INDEX_W-1:0] o_record_index;
    logic                             o_is_new;
    logic                             o_overflow;

    // typed-in answer travels with the request, driven in the same step as the fields
    logic    req_known = 1'b0;
    t_answer req_want = '0;

    // mirror of the dictionary, in arrival order
    t_prop_record interned_records[DICT_DEPTH];
    int           interned_count = 0;

    // answers owed by the block, oldest first
    t_answer pending_answers[$];

    int     mismatch_count = 0;
    int     appended_count = 0;
    int     found_count = 0;
    int     refused_count = 0;
    longint cycle_count = 0;

    // directed rows: extremes, every field differing alone, repeats at first and last entry
    t_directed_row directed_rows[20] = '{
        // 'L','u' lowercase offset 32, into an empty dictionary
        '{'{8'h4c, 8'h75, 22'sd0, 22'sd32, 22'sd0}, 1'b1, '{8'd0, 1'b1, 1'b0}},
        '{'{8'h4c, 8'h75, 22'sd0, 22'sd32, 22'sd0}, 1'b1, '{8'd0, 1'b0, 1'b0}},
        // all zero, all ones, widest positive and negative offsets
        '{'{8'h00, 8'h00, 22'sd0, 22'sd0, 22'sd0}, 1'b1, '{8'd1, 1'b1, 1'b0}},
        '{'{8'hff, 8'hff, -22'sd1, -22'sd1, -22'sd1}, 1'b1, '{8'd2, 1'b1, 1'b0}},
        '{'{8'h00, 8'h00, 22'sh1fffff, 22'sh1fffff, 22'sh1fffff}, 1'b1,
          '{8'd3, 1'b1, 1'b0}},
        '{'{8'h00, 8'h00, 22'sh200000, 22'sh200000, 22'sh200000}, 1'b1,
          '{8'd4, 1'b1, 1'b0}},
        '{'{8'h4c, 8'h6c, -22'sd32, 22'sd0, -22'sd32}, 1'b0, '0},
        '{'{8'h4c, 8'h74, -22'sd1, 22'sd1, 22'sd0}, 1'b0, '0},
        '{'{8'h4c, 8'h75, 22'sd0, 22'sd32, 22'sd0}, 1'b1, '{8'd0, 1'b0, 1'b0}},
        '{'{8'hff, 8'hff, -22'sd1, -22'sd1, -22'sd1}, 1'b1, '{8'd2, 1'b0, 1'b0}},
        // near misses of the first entry, one field at a time
        '{'{8'h4c, 8'h75, 22'sd0, 22'sd32, 22'sd1}, 1'b0, '0},
        '{'{8'h4c, 8'h76, 22'sd0, 22'sd32, 22'sd0}, 1'b0, '0},
        '{'{8'h4d, 8'h75, 22'sd0, 22'sd32, 22'sd0}, 1'b0, '0},
        '{'{8'h4c, 8'h75, 22'sd1, 22'sd32, 22'sd0}, 1'b0, '0},
        '{'{8'h4c, 8'h75, 22'sd0, 22'sd33, 22'sd0}, 1'b0, '0},
        // code point range extremes
        '{'{8'h4e, 8'h64, 22'sd1114111, -22'sd1114111, 22'sd1114111}, 1'b0, '0},
        '{'{8'h4e, 8'h64, -22'sd1114111, 22'sd1114111, -22'sd1114111}, 1'b0, '0},
        // hit on the last entry, then on middle ones
        '{'{8'h4e, 8'h64, -22'sd1114111, 22'sd1114111, -22'sd1114111}, 1'b0, '0},
        '{'{8'h4c, 8'h74, -22'sd1, 22'sd1, 22'sd0}, 1'b0, '0},
        '{'{8'h00, 8'h00, 22'sd0, 22'sd0, 22'sd0}, 1'b1, '{8'd1, 1'b0, 1'b0}}
    };

    property_record_dedup_interner #(
        .DICT_ENTRIES(DICT_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_category_first (i_category_first),
        .i_category_second(i_category_second),
        .i_upper_delta    (i_upper_delta),
        .i_lower_delta    (i_lower_delta),
        .i_title_delta    (i_title_delta),
        .o_result_valid   (o_result_valid),
        .o_record_index   (o_record_index),
        .o_is_new         (o_is_new),
        .o_overflow       (o_overflow)
    );

    // 2 ns period
    always #1 i_clk = ~i_clk;

    // intern one record into the mirror and return what the block must answer
    function automatic t_answer intern_record(input t_prop_record rec);
        t_answer ans;
        int      hit;
        hit = -1;
        // only the filled entries take part in the search
        for (int k = 0; k < interned_count; k++) begin
            if (hit < 0 && interned_records[k] == rec) begin
                hit = k;
            end
        end
        if (hit >= 0) begin
            ans = '{RECORD_INDEX_W'(hit), 1'b0, 1'b0};
            found_count++;
        end else if (interned_count >= DICT_DEPTH) begin
            // full and unknown: nothing stored, index reads zero
            ans = '{'0, 1'b0, 1'b1};
            refused_count++;
        end else begin
            interned_records[interned_count] = rec;
            ans = '{RECORD_INDEX_W'(interned_count), 1'b1, 1'b0};
            interned_count++;
            appended_count++;
        end
        return ans;
    endfunction

    function automatic t_prop_record random_record();
        t_prop_record r;
        r.cat_first   = CAT_W'($urandom_range(255));
        r.cat_second  = CAT_W'($urandom_range(255));
        r.upper_delta = DELTA_W'($urandom);
        r.lower_delta = DELTA_W'($urandom);
        r.title_delta = DELTA_W'($urandom);
        return r;
    endfunction

    // mostly fresh records and exact repeats, plus near misses a single bit away
    function automatic t_prop_record pick_record();
        t_prop_record        r;
        logic [RECORD_W-1:0] flip;
        int unsigned         dice;
        dice = $urandom_range(99);
        if (interned_count == 0 || dice < 40) begin
            r = random_record();
        end else begin
            case ($urandom_range(3))
                0: begin
                    r = interned_records[0];
                end
                1: begin
                    r = interned_records[interned_count - 1];
                end
                default: begin
                    r = interned_records[$urandom_range(interned_count - 1)];
                end
            endcase
            if (dice >= 75) begin
                flip = '0;
                flip[$urandom_range(RECORD_W - 1)] = 1'b1;
                r = r ^ flip;
            end
        end
        return r;
    endfunction

    task automatic drive_fields(input t_prop_record rec);
        i_category_first  <= rec.cat_first;
        i_category_second <= rec.cat_second;
        i_upper_delta     <= rec.upper_delta;
        i_lower_delta     <= rec.lower_delta;
        i_title_delta     <= rec.title_delta;
    endtask

    // present one request after a random gap and hold it until the block takes it
    task automatic issue_request(input t_prop_record rec, input logic known,
                                 input t_answer want, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            // idle cycle with junk on the fields
            start <= 1'b0;
            drive_fields(random_record());
            @(posedge i_clk);
        end
        start     <= 1'b1;
        req_known <= known;
        req_want  <= want;
        drive_fields(rec);
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic note_mismatch(input string what, input t_answer want, input t_answer got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch (%s) at cycle %0d: expected index %0d new %b overflow %b, got index %0d new %b overflow %b",
                     what, cycle_count, want.record_index, want.is_new, want.overflow,
                     got.record_index, got.is_new, got.overflow);
        end
    endtask

    // sample at the edge: check an answer first, then book a newly taken request
    always @(posedge i_clk) begin : answer_check
        t_answer got;
        t_answer want;
        t_answer predicted;
        t_prop_record rec;
        if (i_rst_n) begin
            if (o_result_valid === 1'b1) begin
                got = '{o_record_index, o_is_new, o_overflow};
                if (pending_answers.size() == 0) begin
                    note_mismatch("no request open", '0, got);
                end else begin
                    want = pending_answers.pop_front();
                    if (got.record_index !== want.record_index || got.is_new !== want.is_new
                            || got.overflow !== want.overflow) begin
                        note_mismatch("field", want, got);
                    end
                end
            end
            if (start && !busy) begin
                rec = '{i_category_first, i_category_second, i_upper_delta, i_lower_delta,
                        i_title_delta};
                // mirror always advances; typed-in rows override the prediction
                predicted = intern_record(rec);
                pending_answers.push_back(req_known ? req_want : predicted);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d answers outstanding",
                     cycle_count, pending_answers.size());
            $display("property_record_dedup_interner regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_idle[4];
        // sender gap per phase; the receiver cannot stall, so only the sender idles
        phase_idle = '{0, 53, 0, 36};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            issue_request(directed_rows[n].rec, directed_rows[n].known,
                          directed_rows[n].want, 0);
        end

        // random part: fills the dictionary, then runs long against a full one
        for (int p = 0; p < 4; p++) begin
            repeat (RANDOM_ITEMS / 4) begin
                issue_request(pick_record(), 1'b0, '0, phase_idle[p]);
            end
        end
        start <= 1'b0;

        while (pending_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_answers.size() != 0) begin
            mismatch_count++;
            $display("%0d answers never arrived", pending_answers.size());
        end
        $display("covered %0d requests: %0d appended, %0d found, %0d refused on a full table",
                 appended_count + found_count + refused_count, appended_count, found_count,
                 refused_count);
        $display("dictionary ended with %0d of %0d entries, %0d mismatches over %0d cycles",
                 interned_count, DICT_DEPTH, mismatch_count, cycle_count);
        if (mismatch_count == 0) begin
            $display("property_record_dedup_interner regression: pass");
        end else begin
            $display("property_record_dedup_interner regression: fail");
        end
        $finish;
    end

endmodule

[property_record_dedup_interner.f]
src/prdi_pkg.sv
src/prdi_ram.sv
src/property_record_dedup_interner.sv
src/prdi_checker.sv
tb/sv/tb_top.sv
